### hdl/pwds_pkg.sv
`default_nettype none

package pwds_pkg;

    localparam logic [1:0] KIND_START  = 2'd0;
    localparam logic [1:0] KIND_SAMPLE = 2'd1;
    localparam logic [1:0] KIND_REPORT = 2'd2;

    localparam int DIV_STEPS   = 16;
    localparam int DIV_CNT_W   = $clog2(DIV_STEPS);
    localparam int DUTY_W      = 16;
    localparam int DUR_W       = 32;
    localparam int SQ_W        = 64;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_FSQ,
        ST_FUPD,
        ST_RSQ,
        ST_RPREP,
        ST_DIV,
        ST_OUT
    } state_t;

    typedef struct packed {
        logic start;
        logic sample;
        logic capture;
        logic square;
        logic fall_update;
        logic rep_init;
        logic div_step;
        logic out_load;
    } cmd_t;

    typedef struct packed {
        logic level_now;
        logic div_last;
    } status_t;

endpackage

`default_nettype wire

### hdl/pulse_width_duty_statistics_unit.sv
// Sample without falling edge and start: handled in the idle state; falling edge:
// square (32x32 square register), then accumulate. Report: from accept to m_tvalid
// goes square, sum prep, 16-step restoring divide, output load; next
// item is taken once the result sits in the output register.
// Reset (rst_n low, async): statistics cleared, min all ones, no result pending.
`default_nettype none

module pulse_width_duty_statistics_unit #(
    parameter int TIME_WIDTH = 32
) (
    input  wire logic         clk,
    input  wire logic         rst_n,
    input  wire logic         s_tvalid,
    output logic              s_tready,
    input  wire logic [39:0]  s_tdata,   // time_ticks[31:0], level[32], zero pad
    input  wire logic [1:0]   s_tuser,   // kind[1:0]
    output logic              m_tvalid,
    input  wire logic         m_tready,
    output logic [183:0]      m_tdata    // level_now[0], interval_count[32:1],
                                         // duty_fraction[48:33], sum_sq_duration[112:49],
                                         // min_duration[144:113], max_duration[176:145],
                                         // zero_elapsed[177], zero pad
);
    import pwds_pkg::*;

    cmd_t              cmd;
    status_t           status;
    logic              res_level;
    logic [DUR_W-1:0]  res_count;
    logic [DUTY_W-1:0] res_duty;
    logic [SQ_W-1:0]   res_sum_sq;
    logic [DUR_W-1:0]  res_min;
    logic [DUR_W-1:0]  res_max;
    logic              res_zero;

    pwds_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (s_tvalid),
        .in_kind   (s_tuser),
        .in_level  (s_tdata[32]),
        .in_ready  (s_tready),
        .out_valid (m_tvalid),
        .out_ready (m_tready),
        .status    (status),
        .cmd       (cmd)
    );

    pwds_dpath #(
        .TIME_WIDTH (TIME_WIDTH)
    ) u_dpath (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_time    (s_tdata[31:0]),
        .in_level   (s_tdata[32]),
        .cmd        (cmd),
        .status     (status),
        .res_level  (res_level),
        .res_count  (res_count),
        .res_duty   (res_duty),
        .res_sum_sq (res_sum_sq),
        .res_min    (res_min),
        .res_max    (res_max),
        .res_zero   (res_zero)
    );

    assign m_tdata = {6'd0, res_zero, res_max, res_min, res_sum_sq,
                      res_duty, res_count, res_level};

endmodule

`default_nettype wire

### hdl/pwds_ctrl.sv
`default_nettype none

module pwds_ctrl (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              in_valid,
    input  wire logic [1:0]        in_kind,
    input  wire logic              in_level,
    output logic                   in_ready,
    output logic                   out_valid,
    input  wire logic              out_ready,
    input  wire pwds_pkg::status_t status,
    output pwds_pkg::cmd_t         cmd
);
    import pwds_pkg::*;

    state_t state_reg, state_next;
    logic   m_valid_reg, m_valid_next;
    logic   out_free;
    logic   accept;

    assign out_free  = !m_valid_reg || out_ready;
    assign in_ready  = (state_reg == ST_IDLE);
    assign accept    = in_valid && in_ready;
    assign out_valid = m_valid_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= ST_IDLE;
            m_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg   <= state_next;
            m_valid_reg <= m_valid_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    if (in_kind == KIND_REPORT)
                        state_next = ST_RSQ;
                    else if (in_kind == KIND_SAMPLE && !in_level && status.level_now)
                        state_next = ST_FSQ;
                end
            end
            ST_FSQ:   state_next = ST_FUPD;
            ST_FUPD:  state_next = ST_IDLE;
            ST_RSQ:   state_next = ST_RPREP;
            ST_RPREP: state_next = ST_DIV;
            ST_DIV:
            begin
                if (status.div_last)
                    state_next = ST_OUT;
            end
            ST_OUT:
            begin
                if (out_free)
                    state_next = ST_IDLE;
            end
            default:  state_next = ST_IDLE;
        endcase
    end

    always_comb
    begin
        cmd          = '0;
        m_valid_next = m_valid_reg && !out_ready;
        unique case (state_reg)
            ST_IDLE:
            begin
                cmd.capture = accept;
                cmd.start   = accept && (in_kind == KIND_START);
                cmd.sample  = accept && (in_kind == KIND_SAMPLE);
            end
            ST_FSQ, ST_RSQ: cmd.square      = 1'b1;
            ST_FUPD:        cmd.fall_update = 1'b1;
            ST_RPREP:       cmd.rep_init    = 1'b1;
            ST_DIV:         cmd.div_step    = 1'b1;
            ST_OUT:
            begin
                if (out_free)
                begin
                    cmd.out_load = 1'b1;
                    m_valid_next = 1'b1;
                end
            end
            default: cmd = '0;
        endcase
    end

    a_ready_idle: assert property (@(posedge clk) disable iff (!rst_n)
        in_ready |-> state_reg == ST_IDLE)
        else $error("input taken outside idle");

    a_hold_result: assert property (@(posedge clk) disable iff (!rst_n)
        m_valid_reg && !out_ready |=> m_valid_reg)
        else $error("pending result dropped");

    a_div_end: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == ST_DIV && status.div_last |=> state_reg == ST_OUT)
        else $error("divider did not finish into output");

    a_valid_src: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(m_valid_reg) |-> $past(state_reg) == ST_OUT)
        else $error("result raised outside output state");

endmodule

`default_nettype wire

### hdl/pwds_dpath.sv
`default_nettype none

module pwds_dpath #(
    parameter int TIME_WIDTH = 32
) (
    input  wire logic                        clk,
    input  wire logic                        rst_n,
    input  wire logic [31:0]                 in_time,
    input  wire logic                        in_level,
    input  wire pwds_pkg::cmd_t              cmd,
    output pwds_pkg::status_t                status,
    output logic                             res_level,
    output logic [pwds_pkg::DUR_W-1:0]       res_count,
    output logic [pwds_pkg::DUTY_W-1:0]      res_duty,
    output logic [pwds_pkg::SQ_W-1:0]        res_sum_sq,
    output logic [pwds_pkg::DUR_W-1:0]       res_min,
    output logic [pwds_pkg::DUR_W-1:0]       res_max,
    output logic                             res_zero
);
    import pwds_pkg::*;

    localparam int TW = TIME_WIDTH;
    localparam int DW = (TW > DUR_W) ? TW : DUR_W + 1;
    localparam int RW = ((TW > DUR_W) ? TW : DUR_W) + 1;

    logic                 level_reg;
    logic [TW-1:0]        edge_time_reg;
    logic [TW-1:0]        begin_time_reg;
    logic [DUR_W-1:0]     count_reg;
    logic [DUR_W-1:0]     high_sum_reg;
    logic [SQ_W-1:0]      high_sum_sq_reg;
    logic [DUR_W-1:0]     min_reg;
    logic [DUR_W-1:0]     max_reg;

    logic [DUR_W-1:0]     dur_reg;
    logic                 over_reg;
    logic [TW-1:0]        elapsed_reg;
    logic [SQ_W-1:0]      sq_reg;
    logic [SQ_W-1:0]      rep_sq_reg;
    logic [RW-1:0]        rem_reg;
    logic [DUTY_W-1:0]    quo_reg;
    logic                 sat_reg;
    logic [DIV_CNT_W-1:0] div_cnt_reg;

    logic [TW-1:0]        now;
    logic [TW-1:0]        diff;
    logic [DW-1:0]        diff_ext;
    logic                 diff_over;
    logic                 open_ok;
    logic [DUR_W:0]       sum_add;
    logic [DUR_W-1:0]     sum_sat;
    logic [SQ_W:0]        sq_add;
    logic [SQ_W-1:0]      sq_sat;
    logic [SQ_W-1:0]      prod;
    logic [RW-1:0]        elapsed_ext;
    logic [RW-1:0]        rem_sh;
    logic                 rem_ge;

    assign now       = TW'(in_time);
    assign diff      = now - edge_time_reg;
    assign diff_ext  = DW'(diff);
    assign diff_over = diff_ext > DW'({DUR_W{1'b1}});
    assign open_ok   = cmd.sample || level_reg;

    assign sum_add = {1'b0, high_sum_reg} + {1'b0, dur_reg};
    assign sum_sat = sum_add[DUR_W] ? {DUR_W{1'b1}} : sum_add[DUR_W-1:0];
    assign sq_add  = {1'b0, high_sum_sq_reg} + {1'b0, sq_reg};
    assign sq_sat  = sq_add[SQ_W] ? {SQ_W{1'b1}} : sq_add[SQ_W-1:0];
    assign prod    = SQ_W'(dur_reg) * SQ_W'(dur_reg);

    assign elapsed_ext = RW'(elapsed_reg);
    assign rem_sh      = {rem_reg[RW-2:0], 1'b0};
    assign rem_ge      = rem_sh >= elapsed_ext;

    assign status.level_now = level_reg;
    assign status.div_last  = (div_cnt_reg == DIV_CNT_W'(DIV_STEPS - 1));

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            level_reg       <= 1'b0;
            edge_time_reg   <= '0;
            begin_time_reg  <= '0;
            count_reg       <= '0;
            high_sum_reg    <= '0;
            high_sum_sq_reg <= '0;
            min_reg         <= '1;
            max_reg         <= '0;
        end
        else
        begin
            if (cmd.start)
            begin
                level_reg       <= in_level;
                edge_time_reg   <= now;
                begin_time_reg  <= now;
                count_reg       <= '0;
                high_sum_reg    <= '0;
                high_sum_sq_reg <= '0;
                min_reg         <= '1;
                max_reg         <= '0;
            end
            else if (cmd.sample)
            begin
                if (in_level && !level_reg)
                    edge_time_reg <= now;
                level_reg <= in_level;
            end
            else if (cmd.fall_update)
            begin
                high_sum_reg    <= sum_sat;
                high_sum_sq_reg <= sq_sat;
                if (count_reg != '1)
                    count_reg <= count_reg + 1'b1;
                if (dur_reg < min_reg)
                    min_reg <= dur_reg;
                if (dur_reg > max_reg)
                    max_reg <= dur_reg;
            end
        end
    end

    // report with level low sees an empty open interval
    always_ff @(posedge clk)
    begin
        if (cmd.capture)
        begin
            over_reg    <= open_ok && diff_over;
            dur_reg     <= !open_ok ? '0 :
                           diff_over ? {DUR_W{1'b1}} : diff_ext[DUR_W-1:0];
            elapsed_reg <= now - begin_time_reg;
        end
        if (cmd.square)
            sq_reg <= over_reg ? {SQ_W{1'b1}} : prod;
        if (cmd.rep_init)
        begin
            rep_sq_reg  <= sq_sat;
            rem_reg     <= RW'(sum_sat);
            sat_reg     <= RW'(sum_sat) >= elapsed_ext;
            quo_reg     <= '0;
            div_cnt_reg <= '0;
        end
        if (cmd.div_step)
        begin
            rem_reg     <= rem_ge ? rem_sh - elapsed_ext : rem_sh;
            quo_reg     <= {quo_reg[DUTY_W-2:0], rem_ge};
            div_cnt_reg <= div_cnt_reg + 1'b1;
        end
        if (cmd.out_load)
        begin
            res_level  <= level_reg;
            res_count  <= count_reg;
            res_sum_sq <= rep_sq_reg;
            res_min    <= min_reg;
            res_max    <= max_reg;
            res_zero   <= (elapsed_reg == '0);
            res_duty   <= (elapsed_reg == '0) ? '0 : sat_reg ? '1 : quo_reg;
        end
    end

    a_minmax_order: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg != '0 |-> min_reg <= max_reg)
        else $error("min above max");

    a_empty_stats: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg == '0 |-> min_reg == '1 && max_reg == '0)
        else $error("min or max set with no interval");

    a_rem_bound: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.rep_init || (cmd.div_step && !sat_reg) |=> sat_reg || rem_reg < elapsed_ext)
        else $error("divider remainder out of range");

endmodule

`default_nettype wire
